[src/bps_pkg.sv]
package bps_pkg;

	localparam int unsigned TICK_MS = 20;
	localparam int unsigned CountWidth = 8;
	localparam int unsigned TimeWidth = 16;
	localparam logic [TimeWidth-1:0] TimeMax = '1;
	localparam logic [TimeWidth-1:0] DefaultLength = TimeWidth'(100);

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_START  = 3'd1,
		REQ_STOP   = 3'd2,
		REQ_ON     = 3'd3,
		REQ_OFF    = 3'd4,
		REQ_TOGGLE = 3'd5
	} req_code_t;

	typedef struct packed {
		logic                  pin_level;
		logic                  pattern_active;
		logic                  sounding_phase;
		logic [CountWidth-1:0] beeps_done;
	} result_t;

	typedef struct packed {
		logic                  running;
		logic [CountWidth-1:0] total;
		logic [CountWidth-1:0] done;
	} status_t;

endpackage

[src/bps_if.sv]
interface bps_req_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      req_type;
	logic [bps_pkg::CountWidth-1:0]  beep_count;
	logic [bps_pkg::TimeWidth-1:0]   on_time_ms;
	logic [bps_pkg::TimeWidth-1:0]   off_time_ms;

	modport source (output valid, output req_type, output beep_count,
		output on_time_ms, output off_time_ms, input ready);
	modport sink (input valid, input req_type, input beep_count,
		input on_time_ms, input off_time_ms, output ready);
endinterface

interface bps_res_if;
	logic                            valid;
	logic                            ready;
	logic                            pin_level;
	logic                            pattern_active;
	logic                            sounding_phase;
	logic [bps_pkg::CountWidth-1:0]  beeps_done;

	modport source (output valid, output pin_level, output pattern_active,
		output sounding_phase, output beeps_done, input ready);
	modport sink (input valid, input pin_level, input pattern_active,
		input sounding_phase, input beeps_done, output ready);
endinterface

[src/bps_core.sv]
module bps_core #(
	parameter int unsigned TICK_MS = bps_pkg::TICK_MS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  bps_pkg::req_code_t             req_type,
	input  logic [bps_pkg::CountWidth-1:0] beep_count,
	input  logic [bps_pkg::TimeWidth-1:0]  on_time_ms,
	input  logic [bps_pkg::TimeWidth-1:0]  off_time_ms,
	output bps_pkg::result_t               result,
	output bps_pkg::status_t               status
);

	localparam logic [bps_pkg::TimeWidth:0] TickStep = (bps_pkg::TimeWidth + 1)'(TICK_MS);

	logic                           drive_q, drive_d;
	logic                           phase_q, phase_d;
	logic                           running_q, running_d;
	logic [bps_pkg::CountWidth-1:0] done_q, done_d;
	logic [bps_pkg::CountWidth-1:0] total_q, total_d;
	logic [bps_pkg::TimeWidth-1:0]  beep_len_q, beep_len_d;
	logic [bps_pkg::TimeWidth-1:0]  gap_len_q, gap_len_d;
	logic [bps_pkg::TimeWidth-1:0]  elapsed_q, elapsed_d;
	logic                           pending_q, pending_d;
	logic [bps_pkg::CountWidth-1:0] pend_count_q, pend_count_d;
	logic [bps_pkg::TimeWidth-1:0]  pend_on_q, pend_on_d;
	logic [bps_pkg::TimeWidth-1:0]  pend_off_q, pend_off_d;

	logic [bps_pkg::TimeWidth:0]    elapsed_sum;
	logic [bps_pkg::TimeWidth-1:0]  elapsed_sat;
	logic [bps_pkg::CountWidth-1:0] done_inc;

	assign elapsed_sum = {1'b0, elapsed_q} + TickStep;
	assign elapsed_sat = elapsed_sum[bps_pkg::TimeWidth] ? bps_pkg::TimeMax
		: elapsed_sum[bps_pkg::TimeWidth-1:0];
	assign done_inc = done_q + bps_pkg::CountWidth'(1);

	always_comb begin
		drive_d      = drive_q;
		phase_d      = phase_q;
		running_d    = running_q;
		done_d       = done_q;
		total_d      = total_q;
		beep_len_d   = beep_len_q;
		gap_len_d    = gap_len_q;
		elapsed_d    = elapsed_q;
		pending_d    = pending_q;
		pend_count_d = pend_count_q;
		pend_on_d    = pend_on_q;
		pend_off_d   = pend_off_q;
		case (req_type)
			bps_pkg::REQ_TICK: begin
				elapsed_d = elapsed_sat;
				if (pending_q) begin
					pending_d  = 1'b0;
					running_d  = 1'b1;
					total_d    = pend_count_q;
					done_d     = '0;
					beep_len_d = pend_on_q;
					gap_len_d  = pend_off_q;
					phase_d    = 1'b1;
					elapsed_d  = '0;
				end else if (running_q) begin
					if (phase_q) begin
						if (elapsed_sat >= beep_len_q) begin
							drive_d   = 1'b0;
							phase_d   = 1'b0;
							elapsed_d = '0;
							done_d    = done_inc;
							if (total_q != '0 && done_inc >= total_q) begin
								running_d = 1'b0;
							end
						end
					end else if (elapsed_sat >= gap_len_q
						&& (total_q == '0 || done_q < total_q)) begin
						drive_d   = 1'b1;
						phase_d   = 1'b1;
						elapsed_d = '0;
					end
				end
			end
			bps_pkg::REQ_START: begin
				pend_count_d = beep_count;
				pend_on_d    = on_time_ms;
				pend_off_d   = off_time_ms;
				pending_d    = 1'b1;
				drive_d      = 1'b1;
			end
			bps_pkg::REQ_STOP, bps_pkg::REQ_OFF: begin
				running_d = 1'b0;
				drive_d   = 1'b0;
				phase_d   = 1'b0;
			end
			bps_pkg::REQ_ON: begin
				running_d = 1'b0;
				drive_d   = 1'b1;
				phase_d   = 1'b1;
			end
			bps_pkg::REQ_TOGGLE: begin
				running_d = 1'b0;
				drive_d   = ~drive_q;
				phase_d   = ~phase_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q      <= 1'b0;
			phase_q      <= 1'b0;
			running_q    <= 1'b0;
			done_q       <= '0;
			total_q      <= '0;
			beep_len_q   <= bps_pkg::DefaultLength;
			gap_len_q    <= bps_pkg::DefaultLength;
			elapsed_q    <= '0;
			pending_q    <= 1'b0;
			pend_count_q <= '0;
			pend_on_q    <= '0;
			pend_off_q   <= '0;
		end else if (advance) begin
			drive_q      <= drive_d;
			phase_q      <= phase_d;
			running_q    <= running_d;
			done_q       <= done_d;
			total_q      <= total_d;
			beep_len_q   <= beep_len_d;
			gap_len_q    <= gap_len_d;
			elapsed_q    <= elapsed_d;
			pending_q    <= pending_d;
			pend_count_q <= pend_count_d;
			pend_on_q    <= pend_on_d;
			pend_off_q   <= pend_off_d;
		end
	end

	assign result.pin_level      = drive_d;
	assign result.pattern_active = running_d;
	assign result.sounding_phase = phase_d;
	assign result.beeps_done     = done_d;

	assign status.running = running_q;
	assign status.total   = total_q;
	assign status.done    = done_q;

endmodule

[src/beep_pattern_sequencer.sv]
// Buzzer beep pattern sequencer. Each request item (tick, start, stop, force
// on, force off, toggle) produces one result item carrying the pin level,
// pattern state, phase flag and finished beep count after that request. The
// block accepts one item per cycle while its results are taken without a
// stall; an accepted item waits in the input register, and when it advances
// the combinational state update loads its result into the result register.
// A result that is not taken holds the input register and then the input.
// The tick period is the TICK_MS parameter (default 20 ms); elapsed time
// saturates at 65535 ms.
module beep_pattern_sequencer #(
	parameter int unsigned TICK_MS = bps_pkg::TICK_MS
) (
	input  logic          clk,
	input  logic          arst_n,
	bps_req_if.sink       req,
	bps_res_if.source     res
);

	logic                           valid_s1;
	bps_pkg::req_code_t             req_type_s1;
	logic [bps_pkg::CountWidth-1:0] beep_count_s1;
	logic [bps_pkg::TimeWidth-1:0]  on_time_s1;
	logic [bps_pkg::TimeWidth-1:0]  off_time_s1;

	logic                           res_valid_q;
	bps_pkg::result_t               res_q;
	bps_pkg::result_t               result;
	bps_pkg::status_t               status;
	logic                           advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1   <= bps_pkg::req_code_t'(req.req_type);
			beep_count_s1 <= req.beep_count;
			on_time_s1    <= req.on_time_ms;
			off_time_s1   <= req.off_time_ms;
		end
	end

	bps_core #(
		.TICK_MS (TICK_MS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.req_type    (req_type_s1),
		.beep_count  (beep_count_s1),
		.on_time_ms  (on_time_s1),
		.off_time_ms (off_time_s1),
		.result      (result),
		.status      (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.pin_level      = res_q.pin_level;
	assign res.pattern_active = res_q.pattern_active;
	assign res.sounding_phase = res_q.sounding_phase;
	assign res.beeps_done     = res_q.beeps_done;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_type_s1)
			&& $stable(beep_count_s1)))
		else $error("input stage lost an item while stalled");

	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register did not take an item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(status.running && status.total != '0) |-> (status.done < status.total))
		else $error("pattern running past its beep count");

endmodule

[bench/tb_beep_pattern_sequencer.sv]
module tb_beep_pattern_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned QUIET_TAIL = 200;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned HOLD_AT = 400;
	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef struct {
		logic [2:0]                     kind;
		logic [bps_pkg::CountWidth-1:0] count;
		logic [bps_pkg::TimeWidth-1:0]  on_ms;
		logic [bps_pkg::TimeWidth-1:0]  off_ms;
		bit                             drain;
	} buzzer_req_t;

	typedef struct {
		logic                           drive;
		logic                           phase;
		logic                           run;
		logic [bps_pkg::CountWidth-1:0] done;
		logic [bps_pkg::CountWidth-1:0] total;
		logic [bps_pkg::TimeWidth-1:0]  on_len;
		logic [bps_pkg::TimeWidth-1:0]  off_len;
		logic [bps_pkg::TimeWidth-1:0]  elapsed;
		logic                           pend;
		logic [bps_pkg::CountWidth-1:0] pend_count;
		logic [bps_pkg::TimeWidth-1:0]  pend_on;
		logic [bps_pkg::TimeWidth-1:0]  pend_off;
	} buzzer_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           drv_valid = 1'b0;
	logic [2:0]                     drv_kind = bps_pkg::REQ_TICK;
	logic [bps_pkg::CountWidth-1:0] drv_count = '0;
	logic [bps_pkg::TimeWidth-1:0]  drv_on = '0;
	logic [bps_pkg::TimeWidth-1:0]  drv_off = '0;
	logic                           rcv_ready = 1'b0;

	buzzer_req_t      request_q[$];
	bps_pkg::result_t pin_status_q[$];
	bps_pkg::result_t want;
	buzzer_state_t    bz;

	int unsigned n_sent = 0;
	int unsigned n_recv = 0;
	int unsigned n_total = 0;
	int unsigned send_gap = 0;
	int unsigned hold_left = 0;
	int unsigned fails = 0;
	int unsigned cycle_cnt = 0;
	bit          long_hold_done = 1'b0;
	bit          took;

	bps_req_if req_ch();
	bps_res_if res_ch();

	assign req_ch.valid       = drv_valid;
	assign req_ch.req_type    = drv_kind;
	assign req_ch.beep_count  = drv_count;
	assign req_ch.on_time_ms  = drv_on;
	assign req_ch.off_time_ms = drv_off;
	assign res_ch.ready       = rcv_ready;

	beep_pattern_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always #1 clk = ~clk;

	function automatic bps_pkg::result_t advance_buzzer(buzzer_req_t rq);
		logic [bps_pkg::TimeWidth:0] sum;
		bps_pkg::result_t            r;
		case (rq.kind)
			bps_pkg::REQ_TICK: begin
				sum = {1'b0, bz.elapsed} + (bps_pkg::TimeWidth + 1)'(bps_pkg::TICK_MS);
				bz.elapsed = (sum > (bps_pkg::TimeWidth + 1)'(bps_pkg::TimeMax))
					? bps_pkg::TimeMax : sum[bps_pkg::TimeWidth-1:0];
				if (bz.pend) begin
					bz.pend    = 1'b0;
					bz.run     = 1'b1;
					bz.total   = bz.pend_count;
					bz.done    = '0;
					bz.on_len  = bz.pend_on;
					bz.off_len = bz.pend_off;
					bz.phase   = 1'b1;
					bz.elapsed = '0;
				end else if (bz.run) begin
					if (bz.phase) begin
						if (bz.elapsed >= bz.on_len) begin
							bz.drive   = 1'b0;
							bz.phase   = 1'b0;
							bz.elapsed = '0;
							bz.done    = bz.done + 1'b1;
							if (bz.total != 0 && bz.done >= bz.total)
								bz.run = 1'b0;
						end
					end else if (bz.elapsed >= bz.off_len &&
							(bz.total == 0 || bz.done < bz.total)) begin
						bz.drive   = 1'b1;
						bz.phase   = 1'b1;
						bz.elapsed = '0;
					end
				end
			end
			bps_pkg::REQ_START: begin
				bz.pend_count = rq.count;
				bz.pend_on    = rq.on_ms;
				bz.pend_off   = rq.off_ms;
				bz.pend       = 1'b1;
				bz.drive      = 1'b1;
			end
			bps_pkg::REQ_STOP, bps_pkg::REQ_OFF: begin
				bz.run   = 1'b0;
				bz.drive = 1'b0;
				bz.phase = 1'b0;
			end
			bps_pkg::REQ_ON: begin
				bz.run   = 1'b0;
				bz.drive = 1'b1;
				bz.phase = 1'b1;
			end
			bps_pkg::REQ_TOGGLE: begin
				bz.run   = 1'b0;
				bz.drive = ~bz.drive;
				bz.phase = ~bz.phase;
			end
			default: begin
			end
		endcase
		r.pin_level      = bz.drive;
		r.pattern_active = bz.run;
		r.sounding_phase = bz.phase;
		r.beeps_done     = bz.done;
		return r;
	endfunction

	task automatic add_item(logic [2:0] kind, logic [bps_pkg::CountWidth-1:0] count,
			logic [bps_pkg::TimeWidth-1:0] on_ms, logic [bps_pkg::TimeWidth-1:0] off_ms,
			bit drain);
		buzzer_req_t rq;
		rq.kind   = kind;
		rq.count  = count;
		rq.on_ms  = on_ms;
		rq.off_ms = off_ms;
		rq.drain  = drain;
		request_q.push_back(rq);
	endtask

	task automatic add_ticks(int unsigned n);
		repeat (n) add_item(bps_pkg::REQ_TICK, bps_pkg::CountWidth'($urandom),
			bps_pkg::TimeWidth'($urandom), bps_pkg::TimeWidth'($urandom), 1'b0);
	endtask

	function automatic logic [bps_pkg::TimeWidth-1:0] pick_length();
		if ($urandom_range(0, 7) == 0)
			return bps_pkg::TimeWidth'($urandom);
		return bps_pkg::TimeWidth'($urandom_range(0, 6) * bps_pkg::TICK_MS
			+ $urandom_range(0, 1) * $urandom_range(0, 19));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			took = drv_valid && req_ch.ready;
			if (took) begin
				pin_status_q.push_back(advance_buzzer(request_q.pop_front()));
				n_sent++;
			end
			if (!drv_valid || took) begin
				if (send_gap > 0) begin
					send_gap--;
					drv_valid <= 1'b0;
				end else if (request_q.size() == 0) begin
					drv_valid <= 1'b0;
				end else if (request_q[0].drain && pin_status_q.size() != 0) begin
					drv_valid <= 1'b0;
				end else if (n_sent + QUIET_TAIL < n_total && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 7);
					drv_valid <= 1'b0;
				end else begin
					drv_valid <= 1'b1;
					drv_kind  <= request_q[0].kind;
					drv_count <= request_q[0].count;
					drv_on    <= request_q[0].on_ms;
					drv_off   <= request_q[0].off_ms;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (res_ch.valid && rcv_ready) begin
				if (pin_status_q.size() == 0) begin
					$error("result item with nothing expected");
					fails++;
				end else begin
					want = pin_status_q.pop_front();
					if (res_ch.pin_level !== want.pin_level) begin
						$error("pin_level expected %0d actual %0d", want.pin_level,
							res_ch.pin_level);
						fails++;
					end
					if (res_ch.pattern_active !== want.pattern_active) begin
						$error("pattern_active expected %0d actual %0d", want.pattern_active,
							res_ch.pattern_active);
						fails++;
					end
					if (res_ch.sounding_phase !== want.sounding_phase) begin
						$error("sounding_phase expected %0d actual %0d", want.sounding_phase,
							res_ch.sounding_phase);
						fails++;
					end
					if (res_ch.beeps_done !== want.beeps_done) begin
						$error("beeps_done expected %0d actual %0d", want.beeps_done,
							res_ch.beeps_done);
						fails++;
					end
				end
				n_recv++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rcv_ready <= 1'b0;
			end else if (!long_hold_done && n_recv >= HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				rcv_ready <= 1'b0;
			end else if (n_recv + QUIET_TAIL < n_total && $urandom_range(0, 11) == 0) begin
				hold_left = $urandom_range(0, 7);
				rcv_ready <= 1'b0;
			end else begin
				rcv_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned n_rand;
		int unsigned n_ticks;
		int unsigned roll;
		int unsigned k;

		bz = '{default: '0};
		bz.on_len  = bps_pkg::DefaultLength;
		bz.off_len = bps_pkg::DefaultLength;

		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(REQ_SPARE_LO, '1, '1, '1, 1'b0);
		add_item(REQ_SPARE_HI, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_START, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
		add_item(bps_pkg::REQ_TOGGLE, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TOGGLE, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_ON, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_OFF, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_STOP, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_START, 8'd2, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_STOP, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_START, 8'd0, 16'd20, 16'd40, 1'b1);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TOGGLE, '0, '0, '0, 1'b0);
		add_item(bps_pkg::REQ_TOGGLE, '0, '0, '0, 1'b0);

		// continuous zero-length pattern, long enough to wrap the beep count
		add_item(bps_pkg::REQ_START, 8'd0, '0, '0, 1'b0);
		add_ticks(530);

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 9);
			if (roll <= 6) begin
				add_item(bps_pkg::REQ_START,
					($urandom_range(0, 7) == 0) ? bps_pkg::CountWidth'($urandom)
						: bps_pkg::CountWidth'($urandom_range(0, 4)),
					pick_length(), pick_length(), $urandom_range(0, 40) == 0);
				n_ticks = $urandom_range(1, 30);
				for (k = 0; k < n_ticks; k++) begin
					if ($urandom_range(0, 24) == 0)
						add_item(3'($urandom_range(bps_pkg::REQ_STOP, REQ_SPARE_HI)),
							bps_pkg::CountWidth'($urandom), bps_pkg::TimeWidth'($urandom),
							bps_pkg::TimeWidth'($urandom), 1'b0);
					else
						add_ticks(1);
				end
				n_rand += n_ticks + 1;
			end else begin
				add_item(3'($urandom_range(0, 7)), bps_pkg::CountWidth'($urandom),
					bps_pkg::TimeWidth'($urandom), bps_pkg::TimeWidth'($urandom), 1'b0);
				n_rand++;
			end
		end
		n_total = request_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || drv_valid || pin_status_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
